@@ rtl/subarray_target_sum_window_top_assert.svh @@
// Assertion macros shared by the target-sum window RTL.
`ifndef SUBARRAY_TARGET_SUM_WINDOW_TOP_ASSERT_SVH
`define SUBARRAY_TARGET_SUM_WINDOW_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define STSW_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("stsw assertion failed");
// consequent holds in the same cycle as the antecedent
`define STSW_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stsw assertion failed");
// consequent holds in the cycle after the antecedent
`define STSW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stsw assertion failed");
`else
`define STSW_ASSERT_ALWAYS(lbl, cond)
`define STSW_ASSERT_IMPL(lbl, ante, cons)
`define STSW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/stsw_pkg.sv @@
// Shared constants, codes and types of the target-sum window finder.
package stsw_pkg;

	localparam int MAX_LEN   = 128;
	localparam int ELEM_BITS = 16;
	localparam int IDX_W     = $clog2(MAX_LEN);
	localparam int CNT_W     = IDX_W + 1;
	localparam int TGT_W     = 24;
	localparam int SUM_W     = TGT_W + 1;
	localparam int POS_W     = 8;
	localparam int STAT_W    = 2;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ELEM     = 2'd0;
	localparam kind_t KIND_TOO_LONG = 2'd1;
	localparam kind_t KIND_SKIP     = 2'd2;

	localparam logic [STAT_W-1:0] STAT_FOUND     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_TOO_LONG  = 2'd2;

	typedef struct packed {
		kind_t                kind;
		logic [IDX_W-1:0]     idx;
		logic [ELEM_BITS-1:0] elem;
		logic                 last;
	} q_entry_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  start_pos;
		logic [POS_W-1:0]  end_pos;
	} result_t;

endpackage

@@ rtl/subarray_target_sum_window_top.sv @@
// Top level of the target-sum window finder.
//
//  channel   dir  beat contents                                  handshake
//  cfg       in   cfg_wr_data = target_sum                        cfg_wr_en
//  s_axis    in   tdata = element_value, tlast = last_element     tvalid/tready
//  m_axis    out  tdata = start/end position, tuser = status      tvalid/tready
//
// The back part takes each element that enters the window through the states
// IDLE and CHECK, and each element dropped from its start through CHECK and
// SUB (one store read, one subtract); skipped and overlong elements are taken
// in IDLE alone. A 4-entry queue lets input transfers go on while the back
// part works or a result waits for m_axis_tready.
// Reset clears all control state; the element store needs no clearing.
module subarray_target_sum_window_top
	import stsw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [TGT_W-1:0] cfg_wr_data,   // [23:0] target_sum
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,  // [15:0] element_value
	input  logic             s_axis_tlast,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [7:0] start_position, [15:8] end_position
	output logic [1:0]       m_axis_tuser   // [1:0] status
);

	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_empty;
	q_entry_t q_in;
	q_entry_t q_head;
	result_t  res;

	stsw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_elem  (s_axis_tdata[ELEM_BITS-1:0]),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	stsw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	stsw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res         (res)
	);

	assign m_axis_tdata = {res.end_pos, res.start_pos};
	assign m_axis_tuser = res.status;

endmodule

@@ rtl/stsw_queue.sv @@
// Short FIFO of classified items between the front and back parts.
`include "subarray_target_sum_window_top_assert.svh"

module stsw_queue
	import stsw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     empty
);

	q_entry_t          entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	`STSW_ASSERT_IMPL(a_no_overflow, push, !full || pop)
	`STSW_ASSERT_IMPL(a_no_underflow, pop, !empty)
	`STSW_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= (QPTR_W+1)'(QDEPTH))

endmodule

@@ rtl/stsw_front.sv @@
// Front part: takes input transfers, numbers elements and flags overlong runs.
module stsw_front
	import stsw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ELEM_BITS-1:0] in_elem,
	input  logic                 in_last,
	input  logic                 q_full,
	output logic                 q_push,
	output q_entry_t             q_data
);

	logic [CNT_W-1:0] cnt_q;
	logic             skip_q;
	kind_t            kind;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		if (skip_q)
			kind = KIND_SKIP;
		else if (cnt_q == CNT_W'(MAX_LEN))
			kind = KIND_TOO_LONG;
		else
			kind = KIND_ELEM;
	end

	assign q_data.kind = kind;
	assign q_data.idx  = cnt_q[IDX_W-1:0];
	assign q_data.elem = in_elem;
	assign q_data.last = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			skip_q <= 1'b0;
		end else if (q_push) begin
			if (in_last) begin
				cnt_q  <= '0;
				skip_q <= 1'b0;
			end else if (kind == KIND_TOO_LONG) begin
				// drop the rest of this run
				skip_q <= 1'b1;
			end else if (kind == KIND_ELEM) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/stsw_back.sv @@
// Back part: element store, window sum and result register.
`include "subarray_target_sum_window_top_assert.svh"

module stsw_back
	import stsw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [TGT_W-1:0] cfg_wr_data,
	input  q_entry_t         head,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_SUB   = 2'd2;

	logic [ELEM_BITS-1:0] mem [MAX_LEN];
	logic [ELEM_BITS-1:0] rd_data_q;

	logic [1:0]       state_q;
	logic [TGT_W-1:0] tgt_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] start_q;
	logic [IDX_W-1:0] end_q;
	logic             done_q;
	logic             last_q;
	logic             valid_q;
	result_t          res_q;

	logic             slot_free;
	logic             drop;
	logic             emit;
	result_t          emit_res;
	logic [SUM_W-1:0] tgt_ext;

	assign tgt_ext   = {1'b0, tgt_q};
	assign slot_free = !valid_q || res_ready;
	assign q_pop     = (state_q == S_IDLE) && !q_empty && slot_free;
	assign drop      = (sum_q > tgt_ext) && (start_q <= {1'b0, end_q})
		&& (start_q < CNT_W'(MAX_LEN));

	always_comb begin
		emit     = 1'b0;
		emit_res = '{status: STAT_NOT_FOUND, start_pos: '0, end_pos: '0};
		if (q_pop && !done_q && head.kind == KIND_TOO_LONG) begin
			emit            = 1'b1;
			emit_res.status = STAT_TOO_LONG;
		end else if (state_q == S_CHECK && !drop && slot_free) begin
			if (sum_q == tgt_ext) begin
				emit               = 1'b1;
				emit_res.status    = STAT_FOUND;
				emit_res.start_pos = POS_W'(start_q) + POS_W'(1);
				emit_res.end_pos   = POS_W'(end_q) + POS_W'(1);
			end else if (last_q) begin
				emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q   <= '0;
			sum_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
			done_q  <= 1'b0;
			last_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				tgt_q <= cfg_wr_data;

			if (emit)
				valid_q <= 1'b1;
			else if (res_ready)
				valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (done_q || head.kind == KIND_SKIP
							|| head.kind == KIND_TOO_LONG) begin
							if (head.last) begin
								sum_q   <= '0;
								start_q <= '0;
								end_q   <= '0;
								done_q  <= 1'b0;
							end else if (head.kind == KIND_TOO_LONG) begin
								done_q <= 1'b1;
							end
						end else begin
							if (sum_q < tgt_ext) begin
								sum_q <= sum_q + SUM_W'(head.elem);
								end_q <= head.idx;
							end
							last_q  <= head.last;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (drop) begin
						state_q <= S_SUB;
					end else if (slot_free) begin
						if (last_q) begin
							sum_q   <= '0;
							start_q <= '0;
							end_q   <= '0;
							done_q  <= 1'b0;
						end else if (sum_q == tgt_ext) begin
							done_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_SUB: begin
					// take the oldest element out of the window
					sum_q   <= sum_q - SUM_W'(rd_data_q);
					start_q <= start_q + CNT_W'(1);
					state_q <= S_CHECK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !done_q && head.kind == KIND_ELEM)
			mem[head.idx] <= head.elem;
		if (state_q == S_CHECK && drop)
			rd_data_q <= mem[start_q[IDX_W-1:0]];
		if (emit)
			res_q <= emit_res;
	end

	assign res_valid = valid_q;
	assign res       = res_q;

	`STSW_ASSERT_ALWAYS(a_start_bound, start_q <= {1'b0, end_q} + CNT_W'(1))
	`STSW_ASSERT_NEXT(a_sub_follows_drop, state_q == S_CHECK && drop, state_q == S_SUB)
	`STSW_ASSERT_IMPL(a_found_pos, valid_q && res_q.status == STAT_FOUND,
		res_q.start_pos != '0 && {1'b0, res_q.start_pos} <= {1'b0, res_q.end_pos} + 9'd1)

endmodule
